[hw/rtl/s3pp_pkg.sv]
// Shared types, constants and saturating helpers for the 3x3 partial-pivot solver.
package s3pp_pkg;

  // Fraction bits of the external values and of the internal Q32.32 words
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned INTER_FRAC = 32;
  localparam int unsigned SH         = INTER_FRAC - FRAC_BITS;
  localparam int unsigned QW         = 64;

  typedef logic signed [QW-1:0] q_t;

  localparam q_t Q_MAX     = {1'b0, {(QW-1){1'b1}}};
  localparam q_t Q_MIN     = {1'b1, {(QW-1){1'b0}}};
  localparam q_t S32_MAX_Q = 64'sh0000_0000_7fff_ffff;
  localparam q_t S32_MIN_Q = 64'shffff_ffff_8000_0000;

  // One input transaction: matrix row-major, then right-hand vector
  typedef struct packed {
    logic signed [31:0] a11;
    logic signed [31:0] a12;
    logic signed [31:0] a13;
    logic signed [31:0] a21;
    logic signed [31:0] a22;
    logic signed [31:0] a23;
    logic signed [31:0] a31;
    logic signed [31:0] a32;
    logic signed [31:0] a33;
    logic signed [31:0] b1;
    logic signed [31:0] b2;
    logic signed [31:0] b3;
  } sys_t;

  // One result transaction
  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] x2;
    logic signed [31:0] x3;
    logic               singular;
  } sol_t;

  // Matrix after the first column pivot (column 0 below the diagonal dropped)
  typedef struct packed {
    q_t   r00;
    q_t   r01;
    q_t   r02;
    q_t   r03;
    q_t   r11;
    q_t   r12;
    q_t   r13;
    q_t   r21;
    q_t   r22;
    q_t   r23;
    logic sing;
  } elim0_t;

  // Upper triangle after the second column pivot
  typedef struct packed {
    q_t   r00;
    q_t   r01;
    q_t   r02;
    q_t   r03;
    q_t   r11;
    q_t   r12;
    q_t   r13;
    q_t   r22;
    q_t   r23;
    logic sing;
  } elim1_t;

  // Back substitution, after x3 is known
  typedef struct packed {
    q_t   r00;
    q_t   r01;
    q_t   r03;
    q_t   r11;
    q_t   r13;
    q_t   x3;
    logic sing;
  } back_t;

  // Back substitution, last rows
  typedef struct packed {
    q_t   r00;
    q_t   r01;
    q_t   t0;
    q_t   x2;
    q_t   x3;
    logic sing;
  } last_t;

  function automatic q_t sat_add(q_t a, q_t b);
    logic [QW:0] s;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s[QW] != s[QW-1]) begin
      return s[QW] ? Q_MIN : Q_MAX;
    end
    return s[QW-1:0];
  endfunction

  function automatic q_t sat_sub(q_t a, q_t b);
    logic [QW:0] s;
    s = {a[QW-1], a} - {b[QW-1], b};
    if (s[QW] != s[QW-1]) begin
      return s[QW] ? Q_MIN : Q_MAX;
    end
    return s[QW-1:0];
  endfunction

  function automatic q_t sat_neg(q_t a);
    return (a == Q_MIN) ? Q_MAX : -a;
  endfunction

  function automatic logic [QW-1:0] mag(q_t a);
    return a[QW-1] ? (~a + 64'd1) : a;
  endfunction

endpackage

[hw/rtl/s3pp_div.sv]
// Pipelined Q32.32 divider, one quotient bit per stage, truncating and saturating.
module s3pp_div #(
  parameter int unsigned LANES = 1,
  parameter int unsigned SW    = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [LANES-1:0][63:0] num_i,
  input  logic [LANES-1:0][63:0] den_i,
  input  logic [SW-1:0]          side_i,
  output logic                   valid_o,
  output logic [LANES-1:0][63:0] quo_o,
  output logic [SW-1:0]          side_o
);

  // Quotient bits below the saturation point, and numerator bits above them
  localparam int unsigned NSTEP  = 63;
  localparam int unsigned DSHIFT = 31;

  logic                   pv_q;
  logic [LANES-1:0]       pneg_q;
  logic [LANES-1:0][63:0] pmn_q;
  logic [LANES-1:0][63:0] pmd_q;
  logic [SW-1:0]          pside_q;
  logic [LANES-1:0]       pneg_d;
  logic [LANES-1:0][63:0] pmn_d;
  logic [LANES-1:0][63:0] pmd_d;

  logic                   sv_q    [NSTEP];
  logic [LANES-1:0][63:0] sr_q    [NSTEP];
  logic [LANES-1:0][62:0] sq_q    [NSTEP];
  logic [LANES-1:0]       sovf_q  [NSTEP];
  logic [LANES-1:0]       sdz_q   [NSTEP];
  logic [LANES-1:0]       sneg_q  [NSTEP];
  logic [LANES-1:0][63:0] smn_q   [NSTEP];
  logic [LANES-1:0][63:0] smd_q   [NSTEP];
  logic [SW-1:0]          sside_q [NSTEP];

  logic                   vo_q;
  logic [LANES-1:0][63:0] quo_q;
  logic [LANES-1:0][63:0] quo_d;
  logic [SW-1:0]          so_q;

  // Take magnitudes and the result sign
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      pneg_d[l] = num_i[l][63] ^ den_i[l][63];
      pmn_d[l]  = num_i[l][63] ? (~num_i[l] + 64'd1) : num_i[l];
      pmd_d[l]  = den_i[l][63] ? (~den_i[l] + 64'd1) : den_i[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pneg_q  <= pneg_d;
    pmn_q   <= pmn_d;
    pmd_q   <= pmd_d;
    pside_q <= side_i;
  end

  // One restoring step per stage
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    logic                   v_in;
    logic [LANES-1:0][63:0] r_in;
    logic [LANES-1:0][62:0] q_in;
    logic [LANES-1:0]       ovf_in;
    logic [LANES-1:0]       dz_in;
    logic [LANES-1:0]       neg_in;
    logic [LANES-1:0][63:0] mn_in;
    logic [LANES-1:0][63:0] md_in;
    logic [SW-1:0]          side_in;
    logic [LANES-1:0]       dbit;
    logic [LANES-1:0][63:0] r_d;
    logic [LANES-1:0][62:0] q_d;

    if (k == 0) begin : g_first
      // Seed the remainder; a remainder already at the divisor means overflow
      always_comb begin
        v_in    = pv_q;
        q_in    = '0;
        neg_in  = pneg_q;
        mn_in   = pmn_q;
        md_in   = pmd_q;
        side_in = pside_q;
        for (int l = 0; l < LANES; l++) begin
          r_in[l]   = pmn_q[l] >> DSHIFT;
          ovf_in[l] = (pmn_q[l] >> DSHIFT) >= pmd_q[l];
          dz_in[l]  = (pmd_q[l] == 64'd0);
        end
      end
    end else begin : g_next
      assign v_in    = sv_q[k-1];
      assign r_in    = sr_q[k-1];
      assign q_in    = sq_q[k-1];
      assign ovf_in  = sovf_q[k-1];
      assign dz_in   = sdz_q[k-1];
      assign neg_in  = sneg_q[k-1];
      assign mn_in   = smn_q[k-1];
      assign md_in   = smd_q[k-1];
      assign side_in = sside_q[k-1];
    end

    // Numerator bits feed the upper steps, zeros the fraction steps
    if (k < 31) begin : g_bit
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign dbit[l] = mn_in[l][30-k];
      end
    end else begin : g_zero
      assign dbit = '0;
    end

    always_comb begin
      logic [64:0] t;
      logic        ge;
      for (int l = 0; l < LANES; l++) begin
        t            = {r_in[l], dbit[l]};
        ge           = (t >= {1'b0, md_in[l]});
        r_d[l]       = ge ? 64'(t - {1'b0, md_in[l]}) : t[63:0];
        q_d[l]       = q_in[l];
        q_d[l][62-k] = ge;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k] <= 1'b0;
      end else begin
        sv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sr_q[k]    <= r_d;
      sq_q[k]    <= q_d;
      sovf_q[k]  <= ovf_in;
      sdz_q[k]   <= dz_in;
      sneg_q[k]  <= neg_in;
      smn_q[k]   <= mn_in;
      smd_q[k]   <= md_in;
      sside_q[k] <= side_in;
    end
  end

  // Apply sign, saturate, and drop to zero on a zero divisor
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (sdz_q[NSTEP-1][l]) begin
        quo_d[l] = '0;
      end else if (sovf_q[NSTEP-1][l]) begin
        quo_d[l] = sneg_q[NSTEP-1][l] ? s3pp_pkg::Q_MIN : s3pp_pkg::Q_MAX;
      end else if (sneg_q[NSTEP-1][l]) begin
        quo_d[l] = -{1'b0, sq_q[NSTEP-1][l]};
      end else begin
        quo_d[l] = {1'b0, sq_q[NSTEP-1][l]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= sv_q[NSTEP-1];
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    so_q  <= sside_q[NSTEP-1];
  end

  assign valid_o = vo_q;
  assign quo_o   = quo_q;
  assign side_o  = so_q;

endmodule

[hw/rtl/s3pp_mul.sv]
// Pipelined Q32.32 multiplier: floor of the product, saturated to 64 bits.
module s3pp_mul #(
  parameter int unsigned LANES = 1,
  parameter int unsigned SW    = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [LANES-1:0][63:0] a_i,
  input  logic [LANES-1:0][63:0] b_i,
  input  logic [SW-1:0]          side_i,
  output logic                   valid_o,
  output logic [LANES-1:0][63:0] prod_o,
  output logic [SW-1:0]          side_o
);

  logic [5:0]              v_q;
  logic [SW-1:0]           side_q [6];

  logic [LANES-1:0]        neg1_q, neg2_q, neg3_q, neg4_q, neg5_q;
  logic [LANES-1:0][63:0]  ma1_q, mb1_q;
  logic [LANES-1:0][63:0]  ll2_q, lh2_q, hl2_q, hh2_q;
  logic [LANES-1:0][63:0]  ll3_q, hh3_q;
  logic [LANES-1:0][64:0]  mid3_q;
  logic [LANES-1:0][127:0] p4_q;
  logic [LANES-1:0]        sat5_q;
  logic [LANES-1:0][62:0]  low5_q;
  logic [LANES-1:0][63:0]  prod6_q;

  logic [LANES-1:0]        neg1_d;
  logic [LANES-1:0][63:0]  ma1_d, mb1_d;
  logic [LANES-1:0][63:0]  ll2_d, lh2_d, hl2_d, hh2_d;
  logic [LANES-1:0][64:0]  mid3_d;
  logic [LANES-1:0][127:0] p4_d;
  logic [LANES-1:0]        sat5_d;
  logic [LANES-1:0][62:0]  low5_d;
  logic [LANES-1:0][63:0]  prod6_d;

  always_comb begin
    logic [96:0] qq;
    for (int l = 0; l < LANES; l++) begin
      // Magnitudes and sign
      neg1_d[l] = a_i[l][63] ^ b_i[l][63];
      ma1_d[l]  = a_i[l][63] ? (~a_i[l] + 64'd1) : a_i[l];
      mb1_d[l]  = b_i[l][63] ? (~b_i[l] + 64'd1) : b_i[l];
      // Four 32x32 partial products
      ll2_d[l]  = {32'd0, ma1_q[l][31:0]}  * {32'd0, mb1_q[l][31:0]};
      lh2_d[l]  = {32'd0, ma1_q[l][31:0]}  * {32'd0, mb1_q[l][63:32]};
      hl2_d[l]  = {32'd0, ma1_q[l][63:32]} * {32'd0, mb1_q[l][31:0]};
      hh2_d[l]  = {32'd0, ma1_q[l][63:32]} * {32'd0, mb1_q[l][63:32]};
      // Cross terms, then the full product
      mid3_d[l] = {1'b0, lh2_q[l]} + {1'b0, hl2_q[l]};
      p4_d[l]   = {hh3_q[l], ll3_q[l]} + ({63'd0, mid3_q[l]} << 32);
      // Shift out the fraction, round toward minus infinity
      qq        = {1'b0, p4_q[l][127:32]}
                + {96'd0, (neg4_q[l] && (p4_q[l][31:0] != 32'd0))};
      sat5_d[l] = |qq[96:63];
      low5_d[l] = qq[62:0];
      // Sign and saturate
      if (sat5_q[l]) begin
        prod6_d[l] = neg5_q[l] ? s3pp_pkg::Q_MIN : s3pp_pkg::Q_MAX;
      end else if (neg5_q[l]) begin
        prod6_d[l] = -{1'b0, low5_q[l]};
      end else begin
        prod6_d[l] = {1'b0, low5_q[l]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    neg1_q  <= neg1_d;
    ma1_q   <= ma1_d;
    mb1_q   <= mb1_d;
    neg2_q  <= neg1_q;
    ll2_q   <= ll2_d;
    lh2_q   <= lh2_d;
    hl2_q   <= hl2_d;
    hh2_q   <= hh2_d;
    neg3_q  <= neg2_q;
    ll3_q   <= ll2_q;
    hh3_q   <= hh2_q;
    mid3_q  <= mid3_d;
    neg4_q  <= neg3_q;
    p4_q    <= p4_d;
    neg5_q  <= neg4_q;
    sat5_q  <= sat5_d;
    low5_q  <= low5_d;
    prod6_q <= prod6_d;
    side_q[0] <= side_i;
    for (int s = 1; s < 6; s++) begin
      side_q[s] <= side_q[s-1];
    end
  end

  assign valid_o = v_q[5];
  assign prod_o  = prod6_q;
  assign side_o  = side_q[5];

endmodule

[hw/rtl/solve_3x3_partial_pivot_top.sv]
// Throughput: one system per cycle; busy is always low and every stage holds one item.
// The pipeline chains five dividers, four multipliers and the stage registers v0_q to v12_q.
// Reset clears every valid bit in the pipeline; data registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Top level: 3x3 linear solver with partial pivoting, fully pipelined.
module solve_3x3_partial_pivot_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  s3pp_pkg::sys_t       sys_i,
  output logic                 done_o,
  output s3pp_pkg::sol_t       sol_o
);

  localparam int unsigned E0W = $bits(s3pp_pkg::elim0_t);
  localparam int unsigned E1W = $bits(s3pp_pkg::elim1_t);
  localparam int unsigned BKW = $bits(s3pp_pkg::back_t);
  localparam int unsigned LTW = $bits(s3pp_pkg::last_t);

  function automatic s3pp_pkg::q_t widen(logic signed [31:0] v);
    return s3pp_pkg::q_t'(v) <<< s3pp_pkg::SH;
  endfunction

  function automatic logic signed [31:0] narrow(s3pp_pkg::q_t v);
    s3pp_pkg::q_t s;
    s = v >>> s3pp_pkg::SH;
    if (s > s3pp_pkg::S32_MAX_Q) begin
      return 32'sh7fff_ffff;
    end else if (s < s3pp_pkg::S32_MIN_Q) begin
      return 32'sh8000_0000;
    end
    return s[31:0];
  endfunction

  // Stage registers
  logic                  v0_q, v1_q, v2_q, v3_q, v4_q;
  logic                  v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, v11_q, v12_q;
  s3pp_pkg::sys_t        in_q;
  s3pp_pkg::q_t          m1_q [3][4];
  s3pp_pkg::q_t          m1_d [3][4];
  s3pp_pkg::q_t          m2_q [3][4];
  logic [63:0]           mag2_q [3];
  s3pp_pkg::q_t          m3_q [3][4];
  s3pp_pkg::q_t          m3_d [3][4];
  logic                  sing3_q, sing3_d;
  s3pp_pkg::elim0_t      e4_q;
  s3pp_pkg::q_t          n4_q [2];
  s3pp_pkg::elim0_t      e5_q, e5_d, e6_q, e7_q, e7_d, e8_q;
  logic [63:0]           mag6_q [2];
  s3pp_pkg::q_t          n8_q;
  s3pp_pkg::elim1_t      e9_q, e9_d, e8_1;
  s3pp_pkg::back_t       bk10_q;
  s3pp_pkg::q_t          t0_10_q, t1_10_q;
  s3pp_pkg::last_t       l11_q;
  s3pp_pkg::q_t          t11_q;
  s3pp_pkg::sol_t        sol_q, sol_d;

  // Unit hookups
  logic                  da_v, ma_v, db_v, mb_v, dc_v, mc_v, dd_v, md_v, de_v;
  logic [1:0][63:0]      da_num, da_den, da_quo;
  logic [E0W-1:0]        da_side, ma_side;
  logic [5:0][63:0]      ma_a, ma_b, ma_p;
  logic [0:0][63:0]      db_num, db_den, db_quo;
  logic [E1W-1:0]        db_side, mb_side, dc_side;
  logic [1:0][63:0]      mb_a, mb_b, mb_p;
  logic [0:0][63:0]      dc_num, dc_den, dc_quo;
  logic [1:0][63:0]      mc_a, mc_b, mc_p;
  logic [BKW-1:0]        mc_sin, mc_side;
  logic [0:0][63:0]      dd_num, dd_den, dd_quo;
  logic [LTW-1:0]        dd_sin, dd_side, md_sin, md_side, de_side;
  logic [0:0][63:0]      md_a, md_b, md_p;
  logic [0:0][63:0]      de_num, de_den, de_quo;

  s3pp_pkg::elim0_t      ea;
  s3pp_pkg::elim1_t      eb, ec;
  s3pp_pkg::back_t       bc, bm;
  s3pp_pkg::last_t       ld, lm, ln, le;
  logic [1:0]            best;
  logic [63:0]           bmag;

  assign busy = 1'b0;

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
      v12_q <= 1'b0;
    end else begin
      v0_q  <= start && !busy;
      v1_q  <= v0_q;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= ma_v;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= mb_v;
      v10_q <= mc_v;
      v11_q <= md_v;
      v12_q <= de_v;
    end
  end

  // Widen to Q32.32
  always_comb begin
    m1_d[0][0] = widen(in_q.a11);
    m1_d[0][1] = widen(in_q.a12);
    m1_d[0][2] = widen(in_q.a13);
    m1_d[0][3] = widen(in_q.b1);
    m1_d[1][0] = widen(in_q.a21);
    m1_d[1][1] = widen(in_q.a22);
    m1_d[1][2] = widen(in_q.a23);
    m1_d[1][3] = widen(in_q.b2);
    m1_d[2][0] = widen(in_q.a31);
    m1_d[2][1] = widen(in_q.a32);
    m1_d[2][2] = widen(in_q.a33);
    m1_d[2][3] = widen(in_q.b3);
  end

  // Pick the first row of strictly largest magnitude in column 0, swap it up
  always_comb begin
    best = 2'd0;
    bmag = mag2_q[0];
    if (mag2_q[1] > bmag) begin
      best = 2'd1;
      bmag = mag2_q[1];
    end
    if (mag2_q[2] > bmag) begin
      best = 2'd2;
      bmag = mag2_q[2];
    end
    m3_d = m2_q;
    case (best)
      2'd1: begin
        m3_d[0] = m2_q[1];
        m3_d[1] = m2_q[0];
      end
      2'd2: begin
        m3_d[0] = m2_q[2];
        m3_d[2] = m2_q[0];
      end
      default: begin
      end
    endcase
    sing3_d = (bmag == 64'd0);
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= sys_i;
    end
    m1_q <= m1_d;
    m2_q <= m1_q;
    for (int r = 0; r < 3; r++) begin
      mag2_q[r] <= s3pp_pkg::mag(m1_q[r][0]);
    end
    m3_q    <= m3_d;
    sing3_q <= sing3_d;
    // Negate the column 0 entries below the pivot
    n4_q[0]  <= s3pp_pkg::sat_neg(m3_q[1][0]);
    n4_q[1]  <= s3pp_pkg::sat_neg(m3_q[2][0]);
    e4_q.r00 <= m3_q[0][0];
    e4_q.r01 <= m3_q[0][1];
    e4_q.r02 <= m3_q[0][2];
    e4_q.r03 <= m3_q[0][3];
    e4_q.r11 <= m3_q[1][1];
    e4_q.r12 <= m3_q[1][2];
    e4_q.r13 <= m3_q[1][3];
    e4_q.r21 <= m3_q[2][1];
    e4_q.r22 <= m3_q[2][2];
    e4_q.r23 <= m3_q[2][3];
    e4_q.sing <= sing3_q;
  end

  // Column 0 factors
  assign da_num  = {n4_q[1], n4_q[0]};
  assign da_den  = {e4_q.r00, e4_q.r00};
  assign da_side = e4_q;

  s3pp_div #(.LANES(2), .SW(E0W)) u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .num_i   (da_num),
    .den_i   (da_den),
    .side_i  (da_side),
    .valid_o (da_v),
    .quo_o   (da_quo),
    .side_o  (ea)
  );

  assign ma_a = {da_quo[1], da_quo[1], da_quo[1], da_quo[0], da_quo[0], da_quo[0]};
  assign ma_b = {ea.r03, ea.r02, ea.r01, ea.r03, ea.r02, ea.r01};

  s3pp_mul #(.LANES(6), .SW(E0W)) u_mul_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (da_v),
    .a_i     (ma_a),
    .b_i     (ma_b),
    .side_i  (ea),
    .valid_o (ma_v),
    .prod_o  (ma_p),
    .side_o  (ma_side)
  );

  // Eliminate column 0 from rows 1 and 2
  always_comb begin
    e5_d     = s3pp_pkg::elim0_t'(ma_side);
    e5_d.r11 = s3pp_pkg::sat_add(e5_d.r11, ma_p[0]);
    e5_d.r12 = s3pp_pkg::sat_add(e5_d.r12, ma_p[1]);
    e5_d.r13 = s3pp_pkg::sat_add(e5_d.r13, ma_p[2]);
    e5_d.r21 = s3pp_pkg::sat_add(e5_d.r21, ma_p[3]);
    e5_d.r22 = s3pp_pkg::sat_add(e5_d.r22, ma_p[4]);
    e5_d.r23 = s3pp_pkg::sat_add(e5_d.r23, ma_p[5]);
  end

  // Swap rows 1 and 2 when row 2 has the strictly larger column 1 entry
  always_comb begin
    e7_d = e6_q;
    if (mag6_q[1] > mag6_q[0]) begin
      e7_d.r11 = e6_q.r21;
      e7_d.r12 = e6_q.r22;
      e7_d.r13 = e6_q.r23;
      e7_d.r21 = e6_q.r11;
      e7_d.r22 = e6_q.r12;
      e7_d.r23 = e6_q.r13;
      e7_d.sing = e6_q.sing || (mag6_q[1] == 64'd0);
    end else begin
      e7_d.sing = e6_q.sing || (mag6_q[0] == 64'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    e5_q      <= e5_d;
    e6_q      <= e5_q;
    mag6_q[0] <= s3pp_pkg::mag(e5_q.r11);
    mag6_q[1] <= s3pp_pkg::mag(e5_q.r21);
    e7_q      <= e7_d;
    e8_q      <= e7_q;
    n8_q      <= s3pp_pkg::sat_neg(e7_q.r21);
  end

  // Column 1 factor
  always_comb begin
    e8_1.r00  = e8_q.r00;
    e8_1.r01  = e8_q.r01;
    e8_1.r02  = e8_q.r02;
    e8_1.r03  = e8_q.r03;
    e8_1.r11  = e8_q.r11;
    e8_1.r12  = e8_q.r12;
    e8_1.r13  = e8_q.r13;
    e8_1.r22  = e8_q.r22;
    e8_1.r23  = e8_q.r23;
    e8_1.sing = e8_q.sing;
  end

  assign db_num  = n8_q;
  assign db_den  = e8_q.r11;
  assign db_side = e8_1;

  s3pp_div #(.LANES(1), .SW(E1W)) u_div_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v8_q),
    .num_i   (db_num),
    .den_i   (db_den),
    .side_i  (db_side),
    .valid_o (db_v),
    .quo_o   (db_quo),
    .side_o  (eb)
  );

  assign mb_a = {db_quo[0], db_quo[0]};
  assign mb_b = {eb.r13, eb.r12};

  s3pp_mul #(.LANES(2), .SW(E1W)) u_mul_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (db_v),
    .a_i     (mb_a),
    .b_i     (mb_b),
    .side_i  (eb),
    .valid_o (mb_v),
    .prod_o  (mb_p),
    .side_o  (mb_side)
  );

  // Eliminate column 1 from row 2; a zero last pivot marks the system singular
  always_comb begin
    e9_d      = s3pp_pkg::elim1_t'(mb_side);
    e9_d.r22  = s3pp_pkg::sat_add(e9_d.r22, mb_p[0]);
    e9_d.r23  = s3pp_pkg::sat_add(e9_d.r23, mb_p[1]);
    e9_d.sing = e9_d.sing || (e9_d.r22 == '0);
  end

  always_ff @(posedge clk_i) begin
    e9_q <= e9_d;
  end

  // x3
  assign dc_num  = e9_q.r23;
  assign dc_den  = e9_q.r22;
  assign dc_side = e9_q;

  s3pp_div #(.LANES(1), .SW(E1W)) u_div_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v9_q),
    .num_i   (dc_num),
    .den_i   (dc_den),
    .side_i  (dc_side),
    .valid_o (dc_v),
    .quo_o   (dc_quo),
    .side_o  (ec)
  );

  always_comb begin
    bc.r00  = ec.r00;
    bc.r01  = ec.r01;
    bc.r03  = ec.r03;
    bc.r11  = ec.r11;
    bc.r13  = ec.r13;
    bc.x3   = dc_quo[0];
    bc.sing = ec.sing;
  end

  assign mc_a   = {ec.r02, ec.r12};
  assign mc_b   = {dc_quo[0], dc_quo[0]};
  assign mc_sin = bc;

  s3pp_mul #(.LANES(2), .SW(BKW)) u_mul_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dc_v),
    .a_i     (mc_a),
    .b_i     (mc_b),
    .side_i  (mc_sin),
    .valid_o (mc_v),
    .prod_o  (mc_p),
    .side_o  (mc_side)
  );

  assign bm = s3pp_pkg::back_t'(mc_side);

  // Subtract the x3 terms from rows 1 and 0
  always_ff @(posedge clk_i) begin
    bk10_q  <= bm;
    t1_10_q <= s3pp_pkg::sat_sub(bm.r13, mc_p[0]);
    t0_10_q <= s3pp_pkg::sat_sub(bm.r03, mc_p[1]);
  end

  // x2
  always_comb begin
    ld.r00  = bk10_q.r00;
    ld.r01  = bk10_q.r01;
    ld.t0   = t0_10_q;
    ld.x2   = '0;
    ld.x3   = bk10_q.x3;
    ld.sing = bk10_q.sing;
  end

  assign dd_num = t1_10_q;
  assign dd_den = bk10_q.r11;
  assign dd_sin = ld;

  s3pp_div #(.LANES(1), .SW(LTW)) u_div_d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v10_q),
    .num_i   (dd_num),
    .den_i   (dd_den),
    .side_i  (dd_sin),
    .valid_o (dd_v),
    .quo_o   (dd_quo),
    .side_o  (dd_side)
  );

  always_comb begin
    lm    = s3pp_pkg::last_t'(dd_side);
    lm.x2 = dd_quo[0];
  end

  assign md_a   = lm.r01;
  assign md_b   = dd_quo;
  assign md_sin = lm;

  s3pp_mul #(.LANES(1), .SW(LTW)) u_mul_d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dd_v),
    .a_i     (md_a),
    .b_i     (md_b),
    .side_i  (md_sin),
    .valid_o (md_v),
    .prod_o  (md_p),
    .side_o  (md_side)
  );

  assign ln = s3pp_pkg::last_t'(md_side);

  // Subtract the x2 term from row 0
  always_ff @(posedge clk_i) begin
    l11_q <= ln;
    t11_q <= s3pp_pkg::sat_sub(ln.t0, md_p[0]);
  end

  // x1
  assign de_num = t11_q;
  assign de_den = l11_q.r00;

  s3pp_div #(.LANES(1), .SW(LTW)) u_div_e (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v11_q),
    .num_i   (de_num),
    .den_i   (de_den),
    .side_i  (l11_q),
    .valid_o (de_v),
    .quo_o   (de_quo),
    .side_o  (de_side)
  );

  // Narrow to Q16.16; a singular system gives zeros
  always_comb begin
    le = s3pp_pkg::last_t'(de_side);
    sol_d.singular = le.sing;
    if (le.sing) begin
      sol_d.x1 = '0;
      sol_d.x2 = '0;
      sol_d.x3 = '0;
    end else begin
      sol_d.x1 = narrow(de_quo[0]);
      sol_d.x2 = narrow(le.x2);
      sol_d.x3 = narrow(le.x3);
    end
  end

  always_ff @(posedge clk_i) begin
    sol_q <= sol_d;
  end

  assign done_o = v12_q;
  assign sol_o  = sol_q;

endmodule

[sim/s3pp_checker.sv]
// Checker for the 3x3 partial-pivot solver: predicts each solution and compares it.
module s3pp_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  s3pp_pkg::sys_t sys_i,
  input  logic           done_i,
  input  s3pp_pkg::sol_t sol_i,
  output int             fail_cnt_o,
  output int             pending_cnt_o,
  output int             sol_cnt_o,
  output int             sing_cnt_o
);

  s3pp_pkg::sol_t solq[$];

  // Q32.32 product, floor, saturated to 64 bits
  function automatic s3pp_pkg::q_t q_mul(s3pp_pkg::q_t a, s3pp_pkg::q_t b);
    logic signed [127:0] p;
    logic signed [127:0] s;
    p = 128'(a) * 128'(b);
    s = p >>> 32;
    if (s > 128'(s3pp_pkg::Q_MAX)) return s3pp_pkg::Q_MAX;
    if (s < 128'(s3pp_pkg::Q_MIN)) return s3pp_pkg::Q_MIN;
    return s[63:0];
  endfunction

  // Q32.32 quotient, truncated toward zero, saturated; d nonzero
  function automatic s3pp_pkg::q_t q_div(s3pp_pkg::q_t n, s3pp_pkg::q_t d);
    logic [127:0] mn;
    logic [127:0] md;
    logic [127:0] q;
    logic         neg;
    neg = n[63] ^ d[63];
    mn = {64'd0, s3pp_pkg::mag(n)} << 32;
    md = {64'd0, s3pp_pkg::mag(d)};
    q = mn / md;
    if (q[127:63] != '0) return neg ? s3pp_pkg::Q_MIN : s3pp_pkg::Q_MAX;
    return neg ? -s3pp_pkg::q_t'(q[63:0]) : s3pp_pkg::q_t'(q[63:0]);
  endfunction

  function automatic s3pp_pkg::q_t widen_q(logic signed [31:0] v);
    return s3pp_pkg::q_t'(v) <<< s3pp_pkg::SH;
  endfunction

  function automatic logic signed [31:0] narrow_q(s3pp_pkg::q_t v);
    s3pp_pkg::q_t r;
    r = v >>> s3pp_pkg::SH;
    if (r > s3pp_pkg::S32_MAX_Q) return 32'sh7fff_ffff;
    if (r < s3pp_pkg::S32_MIN_Q) return 32'sh8000_0000;
    return r[31:0];
  endfunction

  // Solve one system by elimination with partial pivoting
  function automatic s3pp_pkg::sol_t solve_sys(s3pp_pkg::sys_t s);
    s3pp_pkg::q_t   m[3][4];
    s3pp_pkg::q_t   t, c, x1, x2, x3;
    int             best;
    s3pp_pkg::sol_t r;
    m[0][0] = widen_q(s.a11); m[0][1] = widen_q(s.a12); m[0][2] = widen_q(s.a13);
    m[1][0] = widen_q(s.a21); m[1][1] = widen_q(s.a22); m[1][2] = widen_q(s.a23);
    m[2][0] = widen_q(s.a31); m[2][1] = widen_q(s.a32); m[2][2] = widen_q(s.a33);
    m[0][3] = widen_q(s.b1);  m[1][3] = widen_q(s.b2);  m[2][3] = widen_q(s.b3);
    r = '0;
    for (int i = 0; i < 3; i++) begin
      best = i;
      for (int k = i + 1; k < 3; k++) begin
        if (s3pp_pkg::mag(m[k][i]) > s3pp_pkg::mag(m[best][i])) best = k;
      end
      for (int j = i; j < 4; j++) begin
        t = m[best][j]; m[best][j] = m[i][j]; m[i][j] = t;
      end
      if (m[i][i] == 0) begin
        r.singular = 1'b1;
        return r;
      end
      for (int k = i + 1; k < 3; k++) begin
        c = q_div(s3pp_pkg::sat_neg(m[k][i]), m[i][i]);
        m[k][i] = 0;
        for (int j = i + 1; j < 4; j++) begin
          m[k][j] = s3pp_pkg::sat_add(m[k][j], q_mul(c, m[i][j]));
        end
      end
    end
    x3 = q_div(m[2][3], m[2][2]);
    x2 = q_div(s3pp_pkg::sat_sub(m[1][3], q_mul(m[1][2], x3)), m[1][1]);
    t  = s3pp_pkg::sat_sub(m[0][3], q_mul(m[0][2], x3));
    t  = s3pp_pkg::sat_sub(t, q_mul(m[0][1], x2));
    x1 = q_div(t, m[0][0]);
    r.x1 = narrow_q(x1);
    r.x2 = narrow_q(x2);
    r.x3 = narrow_q(x3);
    return r;
  endfunction

  // Predict on each accepted system, compare on each result strobe
  always @(posedge clk_i or negedge rst_ni) begin
    s3pp_pkg::sol_t want;
    if (!rst_ni) begin
      fail_cnt_o    <= 0;
      pending_cnt_o <= 0;
      sol_cnt_o     <= 0;
      sing_cnt_o    <= 0;
    end else begin
      if (done_i) begin
        sol_cnt_o <= sol_cnt_o + 1;
        if (solq.size() == 0) begin
          if (fail_cnt_o < 10) $display("ERROR: unexpected result %h", sol_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = solq.pop_front();
          if (sol_i.singular) sing_cnt_o <= sing_cnt_o + 1;
          if (want.x1 !== sol_i.x1 || want.x2 !== sol_i.x2 || want.x3 !== sol_i.x3 ||
              want.singular !== sol_i.singular) begin
            if (fail_cnt_o < 10) begin
              $display("ERROR: x1 exp %h got %h, x2 exp %h got %h", want.x1, sol_i.x1,
                       want.x2, sol_i.x2);
              $display("       x3 exp %h got %h, singular exp %b got %b", want.x3,
                       sol_i.x3, want.singular, sol_i.singular);
            end
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      if (start_i && !busy_i) solq.insert(solq.size(), solve_sys(sys_i));
      pending_cnt_o <= solq.size();
    end
  end

endmodule

[sim/tb_top.sv]
// Testbench top for the 3x3 partial-pivot solver: stimulus and verdict.
module tb_top;

  localparam int N_RAND   = 800;
  localparam int LAT      = 362;
  localparam int MAX_CYC  = 200000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  s3pp_pkg::sys_t sys_i = '0;
  logic           done_o;
  s3pp_pkg::sol_t sol_o;
  int             fail_cnt, pending_cnt, sol_cnt, sing_cnt;
  int             cyc = 0;
  int             sent = 0;

  solve_3x3_partial_pivot_top uut (.*);

  s3pp_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .sys_i         (sys_i),
    .done_i        (done_o),
    .sol_i         (sol_o),
    .fail_cnt_o    (fail_cnt),
    .pending_cnt_o (pending_cnt),
    .sol_cnt_o     (sol_cnt),
    .sing_cnt_o    (sing_cnt)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // End the run at a generous cycle limit
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > MAX_CYC) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 9)) inside
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0;
      3:       return 32'(int'($urandom_range(0, 8)) - 4) << 16;
      4, 5:    return 32'($signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000);
      6:       return $urandom_range(0, 3) << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic s3pp_pkg::sys_t rand_sys();
    s3pp_pkg::sys_t s;
    logic [31:0] e[12];
    for (int i = 0; i < 12; i++) e[i] = rand_elem();
    // Sometimes force a singular or tied column
    if ($urandom_range(0, 7) == 0) begin
      e[0] = 0; e[3] = 0; e[6] = 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      e[3] = e[0]; e[6] = -e[0];
    end
    if ($urandom_range(0, 9) == 0) begin
      e[3] = e[0]; e[4] = e[1]; e[5] = e[2];
    end
    s = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8], e[9], e[10], e[11]};
    return s;
  endfunction

  // Present one system and hold it until accepted
  task automatic send_sys(s3pp_pkg::sys_t s);
    sys_i <= s;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  task automatic drop_start();
    start <= 1'b0;
  endtask

  function automatic s3pp_pkg::sys_t diag_sys(logic [31:0] d1, logic [31:0] d2,
                                              logic [31:0] d3, logic [31:0] b);
    return {d1, 32'h0, 32'h0, 32'h0, d2, 32'h0, 32'h0, 32'h0, d3, b, b, ~b};
  endfunction

  initial begin
    int burst;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity, extremes, zero pivots, ties, pivot swaps, saturation
    send_sys(diag_sys(32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h3_0000));
    send_sys(diag_sys(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    send_sys(diag_sys(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    send_sys(diag_sys(32'h1, 32'h1, 32'h1, 32'h7fff_ffff));
    send_sys(diag_sys(32'hffff_ffff, 32'h1, 32'h8000_0000, 32'h8000_0000));
    send_sys('0);
    send_sys(diag_sys(32'h1_0000, 32'h0, 32'h1_0000, 32'h1_0000));
    send_sys(diag_sys(32'h1_0000, 32'h1_0000, 32'h0, 32'h1_0000));
    send_sys({32'h0, 32'h1_0000, 32'h0, 32'h1_0000, 32'h0, 32'h0,
              32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'h2_0000, 32'h3_0000});
    send_sys({32'h1_0000, 32'h2_0000, 32'h3_0000, 32'hffff_0000, 32'h5_0000, 32'h1_0000,
              32'h1_0000, 32'h0, 32'h2_0000, 32'h1_0000, 32'h0, 32'hffff_0000});
    send_sys({32'h8000_0000, 32'h1_0000, 32'h0, 32'h7fff_ffff, 32'h0, 32'h1_0000,
              32'h8000_0000, 32'h2_0000, 32'h3_0000, 32'h7fff_ffff, 32'h1, 32'h8000_0000});
    send_sys({32'h2_0000, 32'h1_0000, 32'h1_0000, 32'hfffe_0000, 32'h1_0000, 32'h1_0000,
              32'h2_0000, 32'h3_0000, 32'h4_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000});
    send_sys({32'h1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h1, 32'h7fff_ffff,
              32'h0, 32'h0, 32'h1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    send_sys({12{32'hffff_ffff}});
    send_sys({12{32'h5555_aaaa}});
    drop_start();
    @(posedge clk_i);

    // Random bursts with random gaps
    while (sent < 15 + N_RAND) begin
      burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      repeat (burst) send_sys(rand_sys());
      drop_start();
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end

    // Drain and settle
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (LAT / 4) @(posedge clk_i);
    $display("Sent %0d systems, checked %0d solutions, %0d of them singular.",
             sent, sol_cnt, sing_cnt);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
